// ===== rtl/core/ndfsad_pkg.sv =====
// Shared constants and row arithmetic for the near-duplicate frame SAD check.
package ndfsad_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_PIXELS   = 8;
    localparam int DIFF_PIXELS  = 4;
    localparam int BLOCK_ROWS   = 8;
    localparam int DIFF_DIVISOR = 30;

    localparam int ROW_W      = ROW_PIXELS * PIX_W;
    localparam int PIX_MAX    = (2 ** PIX_W) - 1;
    localparam int ROW_SAD_W  = $clog2(ROW_PIXELS * PIX_MAX + 1);
    localparam int ROW_DIFF_W = $clog2(DIFF_PIXELS * PIX_MAX + 1) + 1;
    localparam int ACC_W      = $clog2(BLOCK_ROWS * ROW_PIXELS * PIX_MAX + 1);
    localparam int ROW_CNT_W  = $clog2(BLOCK_ROWS);
    localparam int SUM_W      = 32;
    localparam int PROD_W     = SUM_W + $clog2(DIFF_DIVISOR + 1);

    localparam int BUDGET_W = 31;
    localparam int THR_W    = 14;
    localparam int BUSY_W   = 16;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SAD_BUDGET      = 2'd0;
    localparam logic [1:0] REG_BLOCK_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_BUSY_LIMIT      = 2'd2;

    // sum of absolute pixel differences over one row
    function automatic logic [ROW_SAD_W-1:0] row_sad_f(
        input logic [ROW_W-1:0] cur,
        input logic [ROW_W-1:0] refr
    );
        logic [PIX_W:0]         d;
        logic [PIX_W:0]         a;
        logic [ROW_SAD_W-1:0]   acc;
        acc = '0;
        for (int p = 0; p < ROW_PIXELS; p++)
        begin
            d   = {1'b0, cur[p*PIX_W +: PIX_W]} - {1'b0, refr[p*PIX_W +: PIX_W]};
            a   = d[PIX_W] ? (~d + 1'b1) : d;
            acc = acc + ROW_SAD_W'(a[PIX_W-1:0]);
        end
        return acc;
    endfunction

    // signed difference sum over the left pixels of one row
    function automatic logic signed [ROW_DIFF_W-1:0] row_diff_f(
        input logic [ROW_W-1:0] cur,
        input logic [ROW_W-1:0] refr
    );
        logic [PIX_W:0]                 d;
        logic signed [ROW_DIFF_W-1:0]   acc;
        acc = '0;
        for (int p = 0; p < DIFF_PIXELS; p++)
        begin
            d   = {1'b0, cur[p*PIX_W +: PIX_W]} - {1'b0, refr[p*PIX_W +: PIX_W]};
            acc = acc + $signed({{(ROW_DIFF_W-PIX_W-1){d[PIX_W]}}, d});
        end
        return acc;
    endfunction

endpackage

// ===== rtl/core/near_duplicate_frame_sad_check.sv =====
// Near-duplicate frame check by block SAD: row pipeline, frame state and result register.
//
// Takes one row item (eight current and eight reference luma bytes) per clock unless
// item_stall is high, and gives one result per frame, on the row flagged last_in_frame.
// That row passes the s1, s2, frame-end snapshot and result registers. The row rate is
// set by the frame-state update: block accumulate, threshold and budget compare/subtract
// are combinational. A finished result waits in its own register while rows of the next
// frame keep flowing; a frame end stalls only while two earlier results are still held.
// Budget and busy-limit writes take effect at the next frame start; the block threshold
// is used as it stands when each block closes. The absolute diff test against budget/30
// is done as |sum|*30 > budget.
module near_duplicate_frame_sad_check
    import ndfsad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                item_valid,
    output logic                item_stall,
    input  logic [ROW_W-1:0]    cur_row,
    input  logic [ROW_W-1:0]    ref_row,
    input  logic                last_in_frame,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [BUDGET_W-1:0] remaining_budget
);

    localparam int CMP_W = (ACC_W > THR_W) ? ACC_W : THR_W;

    // configuration
    logic [BUDGET_W-1:0]    cfg_budget_reg;
    logic [THR_W-1:0]       cfg_thr_reg;
    logic [BUSY_W-1:0]      cfg_busy_reg;
    logic                   cfg_write;

    // pipeline
    logic                   s1_valid_reg;
    logic [ROW_W-1:0]       s1_cur_reg;
    logic [ROW_W-1:0]       s1_ref_reg;
    logic                   s1_last_reg;

    logic                           s2_valid_reg;
    logic [ROW_SAD_W-1:0]           s2_sad_reg;
    logic signed [ROW_DIFF_W-1:0]   s2_diff_reg;
    logic                           s2_last_reg;

    // frame state
    logic                       open_reg;
    logic [BUDGET_W-1:0]        budget_left_reg, budget_left_next;
    logic [BUDGET_W-1:0]        frame_budget_reg, frame_budget_next;
    logic [BUSY_W-1:0]          busy_left_reg, busy_left_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [ROW_CNT_W-1:0]       row_reg, row_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       failed_reg, failed_next;

    // frame-end snapshot and result
    logic                       fin_valid_reg;
    logic signed [SUM_W-1:0]    fin_sum_reg;
    logic                       fin_failed_reg;
    logic [BUDGET_W-1:0]        fin_left_reg;
    logic [BUDGET_W-1:0]        fin_fbud_reg;
    logic signed [PROD_W-1:0]   fin_nfbud_reg;
    logic signed [PROD_W-1:0]   nfbud_next;

    logic                   res_valid_reg;
    logic [BUDGET_W-1:0]    res_budget_reg;

    // flow control
    logic res_free, fin_go, fin_free, s2_go, s2_free, s1_free, item_take;

    logic                       start;
    logic [ACC_W-1:0]           acc_sum;
    logic [SUM_W:0]             sum_ext;
    logic                       row_end;
    logic signed [PROD_W-1:0]   prod;
    logic                       too_diff;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAD_BUDGET:      prdata = DATA_W'(cfg_budget_reg);
            REG_BLOCK_THRESHOLD: prdata = DATA_W'(cfg_thr_reg);
            REG_BUSY_LIMIT:      prdata = DATA_W'(cfg_busy_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_budget_reg <= '0;
            cfg_thr_reg    <= '0;
            cfg_busy_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SAD_BUDGET:      cfg_budget_reg <= pwdata[BUDGET_W-1:0];
                REG_BLOCK_THRESHOLD: cfg_thr_reg    <= pwdata[THR_W-1:0];
                REG_BUSY_LIMIT:      cfg_busy_reg   <= pwdata[BUSY_W-1:0];
                default:             ;
            endcase
        end
    end

    assign res_free   = !res_valid_reg || !result_stall;
    assign fin_go     = fin_valid_reg && res_free;
    assign fin_free   = !fin_valid_reg || res_free;
    assign s2_go      = s2_valid_reg && (!s2_last_reg || fin_free);
    assign s2_free    = !s2_valid_reg || s2_go;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item_stall = !s1_free;
    assign item_take  = item_valid && s1_free;

    // frame state update for the row in stage 2
    always_comb
    begin
        start             = !open_reg;
        budget_left_next  = start ? cfg_budget_reg : budget_left_reg;
        frame_budget_next = start ? cfg_budget_reg : frame_budget_reg;
        busy_left_next    = start ? cfg_busy_reg : busy_left_reg;
        acc_next          = start ? '0 : acc_reg;
        row_next          = start ? '0 : row_reg;
        sum_next          = start ? '0 : sum_reg;
        failed_next       = start ? 1'b0 : failed_reg;

        acc_sum = acc_next + ACC_W'(s2_sad_reg);
        row_end = (row_next == ROW_CNT_W'(BLOCK_ROWS - 1));
        sum_ext = {sum_next[SUM_W-1], sum_next}
                + {{(SUM_W+1-ROW_DIFF_W){s2_diff_reg[ROW_DIFF_W-1]}}, s2_diff_reg};

        if (!failed_next)
        begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            else
                sum_next = $signed(sum_ext[SUM_W-1:0]);

            if (row_end)
            begin
                acc_next = '0;
                row_next = '0;
                if (CMP_W'(acc_sum) > CMP_W'(cfg_thr_reg))
                begin
                    if (busy_left_next == '0)
                        failed_next = 1'b1;
                    else
                        busy_left_next = busy_left_next - 1'b1;
                end
                if (!failed_next)
                begin
                    if (BUDGET_W'(acc_sum) > budget_left_next)
                        failed_next = 1'b1;
                    else
                        budget_left_next = budget_left_next - BUDGET_W'(acc_sum);
                end
            end
            else
            begin
                acc_next = acc_sum;
                row_next = ROW_CNT_W'(row_next + 1'b1);
            end
        end

        nfbud_next = PROD_W'(0) - $signed(PROD_W'(frame_budget_next));
    end

    assign prod     = PROD_W'(fin_sum_reg) * $signed(PROD_W'(DIFF_DIVISOR));
    assign too_diff = (prod > $signed(PROD_W'(fin_fbud_reg))) || (prod < fin_nfbud_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            fin_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            open_reg         <= 1'b0;
            budget_left_reg  <= '0;
            frame_budget_reg <= '0;
            busy_left_reg    <= '0;
            acc_reg          <= '0;
            row_reg          <= '0;
            sum_reg          <= '0;
            failed_reg       <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= item_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;

            if (s2_go)
            begin
                open_reg         <= !s2_last_reg;
                budget_left_reg  <= budget_left_next;
                frame_budget_reg <= frame_budget_next;
                busy_left_reg    <= busy_left_next;
                acc_reg          <= acc_next;
                row_reg          <= row_next;
                sum_reg          <= sum_next;
                failed_reg       <= failed_next;
            end

            if (s2_go && s2_last_reg)
                fin_valid_reg <= 1'b1;
            else if (fin_go)
                fin_valid_reg <= 1'b0;

            if (fin_go)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_cur_reg  <= cur_row;
            s1_ref_reg  <= ref_row;
            s1_last_reg <= last_in_frame;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_sad_reg  <= row_sad_f(s1_cur_reg, s1_ref_reg);
            s2_diff_reg <= row_diff_f(s1_cur_reg, s1_ref_reg);
            s2_last_reg <= s1_last_reg;
        end
        if (s2_go && s2_last_reg)
        begin
            fin_sum_reg    <= sum_next;
            fin_failed_reg <= failed_next;
            fin_left_reg   <= budget_left_next;
            fin_fbud_reg   <= frame_budget_next;
            fin_nfbud_reg  <= nfbud_next;
        end
        if (fin_go)
            res_budget_reg <= (fin_failed_reg || too_diff) ? '0 : fin_left_reg;
    end

    assign result_valid     = res_valid_reg;
    assign remaining_budget = res_budget_reg;

    // a failed frame leaves the budget alone until frame end
    a_failed_budget_frozen: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s2_go && open_reg && failed_reg) |=> $stable(budget_left_reg)
    ) else $error("budget changed in a failed frame");

    // budget only shrinks within a frame
    a_budget_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s2_go && open_reg) |=> (budget_left_reg <= $past(budget_left_reg))
    ) else $error("budget grew within a frame");

    // input stalls only while the input register holds an item
    a_stall_has_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg
    ) else $error("input stalled with empty row stage");

endmodule

// ===== verif/testbench.sv =====
// Testbench for near_duplicate_frame_sad_check: frame stimulus, frame-result predictor, checks.
`timescale 1ns / 100ps

module testbench;
    import ndfsad_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 6;

    // predicts the per-frame remaining budget from the accepted rows
    class frame_sad_scoreboard;
        logic [BUDGET_W-1:0] sad_budget;
        logic [THR_W-1:0]    block_threshold;
        logic [BUSY_W-1:0]   busy_block_limit;

        longint              budget_left;
        longint              frame_budget;
        int unsigned         busy_left;
        int unsigned         block_sad;
        int unsigned         rows_in_block;
        longint              diff_sum;
        bit                  failed;
        bit                  in_frame;

        logic [BUDGET_W-1:0] expected_budgets[$];
        int                  errors;

        function new();
            sad_budget       = '0;
            block_threshold  = '0;
            busy_block_limit = '0;
            budget_left      = 0;
            frame_budget     = 0;
            busy_left        = 0;
            block_sad        = 0;
            rows_in_block    = 0;
            diff_sum         = 0;
            failed           = 1'b0;
            in_frame         = 1'b0;
            errors           = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_SAD_BUDGET:      sad_budget       = value[BUDGET_W-1:0];
                REG_BLOCK_THRESHOLD: block_threshold  = value[THR_W-1:0];
                REG_BUSY_LIMIT:      busy_block_limit = value[BUSY_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_row(logic [ROW_W-1:0] cur, logic [ROW_W-1:0] refr, logic last);
            int unsigned row_sad;
            int          row_diff;
            int          c;
            int          r;
            int          d;
            longint      mag;
            row_sad  = 0;
            row_diff = 0;
            if (!in_frame)
            begin
                budget_left   = sad_budget;
                frame_budget  = sad_budget;
                busy_left     = busy_block_limit;
                block_sad     = 0;
                rows_in_block = 0;
                diff_sum      = 0;
                failed        = 1'b0;
                in_frame      = 1'b1;
            end
            for (int p = 0; p < ROW_PIXELS; p++)
            begin
                c = cur[p*PIX_W +: PIX_W];
                r = refr[p*PIX_W +: PIX_W];
                d = c - r;
                row_sad += (d < 0) ? -d : d;
                if (p < DIFF_PIXELS)
                    row_diff += d;
            end
            if (!failed)
            begin
                diff_sum += row_diff;
                if (diff_sum > 64'sd2147483647)
                    diff_sum = 64'sd2147483647;
                if (diff_sum < -64'sd2147483648)
                    diff_sum = -64'sd2147483648;
                block_sad += row_sad;
                rows_in_block++;
                if (rows_in_block >= BLOCK_ROWS)
                begin
                    if (block_sad > int'(block_threshold))
                    begin
                        if (busy_left == 0)
                            failed = 1'b1;
                        else
                            busy_left--;
                    end
                    if (!failed)
                    begin
                        if (block_sad > budget_left)
                            failed = 1'b1;
                        else
                            budget_left -= block_sad;
                    end
                    block_sad     = 0;
                    rows_in_block = 0;
                end
            end
            if (last)
            begin
                mag = (diff_sum < 0) ? -diff_sum : diff_sum;
                if (failed || mag > frame_budget / DIFF_DIVISOR)
                    expected_budgets.push_back('0);
                else
                    expected_budgets.push_back(budget_left[BUDGET_W-1:0]);
                in_frame = 1'b0;
            end
        endfunction

        function void check_result(logic [BUDGET_W-1:0] got);
            logic [BUDGET_W-1:0] want;
            if (expected_budgets.size() == 0)
            begin
                $error("remaining_budget: no frame result pending, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_budgets.pop_front();
                if (got !== want)
                begin
                    $error("remaining_budget: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_budgets.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid;
    logic                item_stall;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    ref_row;
    logic                last_in_frame;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [BUDGET_W-1:0] remaining_budget;

    frame_sad_scoreboard sb;
    int                  rows_sent;
    int                  burst_left;
    int                  idle_cycles;
    int                  stall_mode;
    int                  stall_left;

    near_duplicate_frame_sad_check uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .cur_row          (cur_row),
        .ref_row          (ref_row),
        .last_in_frame    (last_in_frame),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .remaining_budget (remaining_budget)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side stall pattern
    initial
    begin
        stall_mode = 0;
        stall_left = 0;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= $urandom_range(0, 1);
            2: result_stall <= ($urandom_range(0, 7) != 0);
            default: result_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_row(cur_row, ref_row, last_in_frame);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(remaining_budget);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_row(input logic [ROW_W-1:0] cur, input logic [ROW_W-1:0] refr,
                            input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_valid    <= 1'b1;
        cur_row       <= cur;
        ref_row       <= refr;
        last_in_frame <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        rows_sent++;
    endtask

    task automatic send_frame(input int nrows, input bit noise);
        logic [ROW_W-1:0] cur;
        logic [ROW_W-1:0] refr;
        logic [PIX_W-1:0] mask;
        mask = 8'h0F >> $urandom_range(0, 4);
        for (int i = 0; i < nrows; i++)
        begin
            cur = {$urandom, $urandom};
            if (noise)
                refr = {$urandom, $urandom};
            else
                refr = cur ^ ({$urandom, $urandom} & {ROW_PIXELS{mask}});
            send_row(cur, refr, i == nrows - 1);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // drain all frame results, then rewrite the registers
    task automatic set_regs(input logic [DATA_W-1:0] budget, input logic [DATA_W-1:0] thr,
                            input logic [DATA_W-1:0] busy);
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        apb_write(REG_SAD_BUDGET, budget);
        apb_write(REG_BLOCK_THRESHOLD, thr);
        apb_write(REG_BUSY_LIMIT, busy);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        burst_left = 0;
    endtask

    task automatic random_regs();
        logic [DATA_W-1:0] budget;
        logic [DATA_W-1:0] thr;
        logic [DATA_W-1:0] busy;
        case ($urandom_range(0, 9))
            0:       budget = 0;
            1:       budget = 32'h7FFF_FFFF;
            default: budget = $urandom_range(0, 8000);
        endcase
        case ($urandom_range(0, 9))
            0:       thr = 0;
            1:       thr = 16320;
            default: thr = $urandom_range(0, 800);
        endcase
        case ($urandom_range(0, 9))
            0:       busy = 0;
            1:       busy = 65535;
            default: busy = $urandom_range(0, 6);
        endcase
        set_regs(budget, thr, busy);
    endtask

    initial
    begin
        logic [ROW_W-1:0] pix;
        int               frames;
        int               nrows;
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_valid    = 1'b0;
        cur_row       = '0;
        ref_row       = '0;
        last_in_frame = 1'b0;
        rows_sent     = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        frames        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // full-scale rows; block SAD equals the budget exactly
        set_regs(16320, 16320, 65535);
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                send_row({ROW_W{1'b1}}, '0, 1'b0);
            else
                send_row('0, {ROW_W{1'b1}}, 1'b0);
        end
        pix = {$urandom, $urandom};
        send_row(pix, pix, 1'b1);
        // one-row frame
        pix = {$urandom, $urandom};
        send_row(pix, pix, 1'b1);
        // frame ends inside a block
        for (int i = 0; i < 3; i++)
        begin
            pix = {$urandom, $urandom};
            send_row(pix, pix ^ {ROW_PIXELS{8'h01}}, i == 2);
        end

        // busy block with no allowance, then rows of a failed frame
        set_regs(32'h7FFF_FFFF, 0, 0);
        for (int i = 0; i < 8; i++)
        begin
            pix = {$urandom, $urandom};
            send_row(pix, pix ^ 64'h1, 1'b0);
        end
        send_row({ROW_W{1'b1}}, '0, 1'b0);
        send_row('0, {ROW_W{1'b1}}, 1'b1);

        // zero budget
        set_regs(0, 16320, 65535);
        pix = {$urandom, $urandom};
        send_row(pix, pix, 1'b1);

        while (rows_sent < ITEM_TARGET)
        begin
            if (frames % 6 == 0)
                random_regs();
            if ($urandom_range(0, 9) == 0)
                nrows = BLOCK_ROWS * $urandom_range(5, 12);
            else
                nrows = BLOCK_ROWS * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0)
                nrows += $urandom_range(1, BLOCK_ROWS - 1);
            send_frame(nrows, $urandom_range(0, 9) == 0);
            frames++;
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
